@@ hdl/serl_pkg.sv @@
// Package for the sequenced event ring log: widths, opcodes, status codes,
// record layout, controller states and the CRC-8 column table.
// No dependencies; imported by serl_crc, the top module and the testbench.
package serl_pkg;

   localparam int CAPACITY = 4096;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CNTX_W   = CNT_W + 1;
   localparam int SEQ_W    = 64;
   localparam int REC_W    = 72;
   localparam int MSG_W    = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   localparam logic [7:0] CRC_POLY = 8'h07;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_TIME_SRC  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_EVENT_SRC = 2'd1;

   typedef enum logic [1:0] {
      OP_APPEND      = 2'd0,
      OP_READ_SEQ    = 2'd1,
      OP_READ_NEWEST = 2'd2,
      OP_ALIGN       = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_NOT_PRESENT   = 3'd1,
      ST_INVALID       = 3'd2,
      ST_TAG_MISMATCH  = 3'd3,
      ST_ALIGN_REFUSED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPEND,
      S_RANGE,
      S_CHECK,
      S_ALIGN,
      S_ALIGN2,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic        abs_valid;
      logic [2:0]  event_src;
      logic [2:0]  time_src;
      logic [16:0] delta;
      logic [31:0] time_s;
   } body_type;

   typedef struct packed {
      logic [7:0] crc;
      body_type   body;
   } record_type;

   typedef struct packed {
      status_type       status;
      logic [SEQ_W-1:0] seq;
      logic [31:0]      time_s;
      logic [16:0]      delta;
      logic [2:0]       time_src;
      logic [2:0]       event_src;
      logic             abs_valid;
      logic [CNT_W-1:0] count;
   } result_type;

   // CRC of a 64-bit message with a single bit set, MSB of the first byte first
   function automatic logic [MSG_W-1:0][7:0] crc_columns();
      logic [MSG_W-1:0][7:0] cols;
      logic [7:0]            c;
      logic                  fb;
      for (int j = 0; j < MSG_W; j++) begin
         c = 8'h00;
         for (int i = MSG_W - 1; i >= 0; i--) begin
            fb = c[7] ^ (i == j);
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
         end
         cols[j] = c;
      end
      return cols;
   endfunction

   localparam logic [MSG_W-1:0][7:0] CRC_COLS = crc_columns();

endpackage

@@ hdl/serl_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data registered. No dependencies.
module serl_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ hdl/serl_crc.sv @@
// CRC-8 (poly 0x07, zero init, MSB first) over the eight body bytes of a record.
// Parallel XOR network built from the column table in serl_pkg.
module serl_crc (
   input  serl_pkg::body_type body,
   output logic [7:0]         crc
);
   import serl_pkg::*;

   logic [MSG_W-1:0] msg;

   assign msg = {body.time_s[7:0], body.time_s[15:8], body.time_s[23:16], body.time_s[31:24],
                 body.delta[7:0], body.delta[15:8],
                 body.abs_valid, body.event_src, body.time_src, body.delta[16],
                 body.tag};

   always_comb begin
      crc = 8'h00;
      for (int j = 0; j < MSG_W; j++) begin
         crc = crc ^ (msg[j] ? CRC_COLS[j] : 8'h00);
      end
   end

endmodule

@@ hdl/sequenced_event_ring_log.sv @@
// Sequenced event ring log: ring of CRC-8 protected event records in one RAM,
// indexed by a 64-bit running sequence. Uses serl_pkg, serl_ram and serl_crc.
//
// Usage:
//   req_* carries one request (append, read by sequence, read newest, align).
//   rsp_* returns exactly one response per request, in request order.
//   csr_* writes the two source limits; write only while the block is idle.
// Flow:
//   append       : the request passes S_APPEND, then S_DONE loads the response.
//   reads, align : S_RANGE, S_CHECK or S_ALIGN, S_ALIGN2, then S_DONE loads it.
//   A new request is taken in the cycle the response register is loaded,
//   so the block works on one request at a time.
//   Reads go through the record RAM with its registered read and then
//   the CRC check that follows it.
// Reset:
//   synchronous; the log is empty, sequence 0, both limits 7. No clearing
//   pass: an entry is only read after an append wrote it.
// Stall:
//   a held response stays in the output register while one more request is
//   worked on; that request then waits in its final state until rsp_ready.
module sequenced_event_ring_log (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_opcode,
   input  logic [31:0]                      req_time_seconds,
   input  logic [16:0]                      req_delta_seconds,
   input  logic [2:0]                       req_time_source,
   input  logic [2:0]                       req_event_source,
   input  logic                             req_absolute_valid,
   input  logic [63:0]                      req_sequence_req,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_status,
   output logic [63:0]                      rsp_result_sequence,
   output logic [31:0]                      rsp_out_time_seconds,
   output logic [16:0]                      rsp_out_delta_seconds,
   output logic [2:0]                       rsp_out_time_source,
   output logic [2:0]                       rsp_out_event_source,
   output logic                             rsp_out_absolute_valid,
   output logic [12:0]                      rsp_entry_count,
   input  logic                             csr_we,
   input  logic [serl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [serl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import serl_pkg::*;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [31:0]      time_ff, time_in;
   logic [16:0]      delta_ff, delta_in;
   logic [2:0]       tsrc_ff, tsrc_in;
   logic [2:0]       esrc_ff, esrc_in;
   logic             abs_ff, abs_in;
   logic [SEQ_W-1:0] req_seq_ff, req_seq_in;
   logic [SEQ_W-1:0] work_seq_ff, work_seq_in;
   logic             flag_ff, flag_in;
   logic [SEQ_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SEQ_W-1:0] oldest_ff, oldest_in;
   logic [SLOT_W-1:0] oslot_ff, oslot_in;
   logic [2:0]       max_ts_ff, max_ts_in;
   logic [2:0]       max_es_ff, max_es_in;
   result_type       res_ff, res_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept, can_push;
   logic [SEQ_W-1:0] app_seq;
   record_type       new_rec;
   logic [7:0]       app_crc;
   record_type       rd_rec;
   logic [7:0]       chk_crc;
   logic [REC_W-1:0] ram_rdata;
   logic             ram_we;
   logic [SEQ_W-1:0] rd_seq, rd_off;
   logic             in_range;
   logic [CNTX_W-1:0] idx_sum, idx_wrap, oslot_sum, oslot_wrap;
   logic [SLOT_W-1:0] rd_idx;
   logic [7:0]       fwd;
   logic [SEQ_W-1:0] aligned;
   logic             align_gt, refuse, rec_ok;

   assign can_push  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && can_push);
   assign accept    = req_valid && req_ready;

   // append record
   assign app_seq                = last_ff + SEQ_W'(1);
   assign new_rec.body.tag       = app_seq[7:0];
   assign new_rec.body.abs_valid = abs_ff;
   assign new_rec.body.event_src = esrc_ff;
   assign new_rec.body.time_src  = tsrc_ff;
   assign new_rec.body.delta     = delta_ff;
   assign new_rec.body.time_s    = time_ff;
   assign new_rec.crc            = app_crc;

   serl_crc u_crc_app (
      .body (new_rec.body),
      .crc  (app_crc)
   );

   // range check and RAM index
   assign rd_seq   = (op_ff == OP_READ_NEWEST) ? last_ff : req_seq_ff;
   assign rd_off   = rd_seq - oldest_ff;
   assign in_range = (count_ff != '0) && (rd_off[SEQ_W-1:CNT_W] == '0)
                     && (rd_off[CNT_W-1:0] < count_ff);
   assign idx_sum  = CNTX_W'(oslot_ff) + CNTX_W'(rd_off[CNT_W-1:0]);
   assign idx_wrap = (idx_sum >= CNTX_W'(CAPACITY)) ? idx_sum - CNTX_W'(CAPACITY) : idx_sum;
   assign rd_idx   = idx_wrap[SLOT_W-1:0];

   serl_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (new_rec),
      .raddr (rd_idx),
      .rdata (ram_rdata)
   );

   // record check
   assign rd_rec = record_type'(ram_rdata);

   serl_crc u_crc_chk (
      .body (rd_rec.body),
      .crc  (chk_crc)
   );

   assign rec_ok = (chk_crc == rd_rec.crc) && (rd_rec.body.time_src <= max_ts_ff)
                   && (rd_rec.body.event_src <= max_es_ff);

   // align
   assign fwd      = last_ff[7:0] - req_seq_ff[7:0];
   assign aligned  = (count_ff == '0) ? req_seq_ff : req_seq_ff + SEQ_W'(fwd);
   assign align_gt = req_seq_ff > last_ff;
   assign refuse   = flag_ff && (count_ff != '0) && (work_seq_ff < last_ff);

   // oldest slot derived from write slot and count
   assign oslot_sum  = CNTX_W'(slot_ff) + CNTX_W'(CAPACITY) - CNTX_W'(count_ff);
   assign oslot_wrap = (oslot_sum >= CNTX_W'(CAPACITY)) ? oslot_sum - CNTX_W'(CAPACITY)
                                                         : oslot_sum;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      time_in      = time_ff;
      delta_in     = delta_ff;
      tsrc_in      = tsrc_ff;
      esrc_in      = esrc_ff;
      abs_in       = abs_ff;
      req_seq_in   = req_seq_ff;
      work_seq_in  = work_seq_ff;
      flag_in      = flag_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      oldest_in    = oldest_ff;
      oslot_in     = oslot_ff;
      max_ts_in    = max_ts_ff;
      max_es_in    = max_es_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            state_in = S_IDLE;
         end
         S_APPEND: begin
            ram_we  = 1'b1;
            last_in = app_seq;
            slot_in = (slot_ff == SLOT_W'(CAPACITY - 1)) ? '0 : slot_ff + SLOT_W'(1);
            if (count_ff < CNT_W'(CAPACITY)) begin
               count_in = count_ff + CNT_W'(1);
            end
            res_in        = '0;
            res_in.status = ST_OK;
            res_in.seq    = app_seq;
            state_in      = S_DONE;
         end
         S_RANGE: begin
            work_seq_in = rd_seq;
            flag_in     = in_range;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            res_in     = '0;
            res_in.seq = work_seq_ff;
            if (!flag_ff) begin
               res_in.status = ST_NOT_PRESENT;
            end else if (!rec_ok) begin
               res_in.status = ST_INVALID;
            end else begin
               res_in.time_s    = rd_rec.body.time_s;
               res_in.delta     = rd_rec.body.delta;
               res_in.time_src  = rd_rec.body.time_src;
               res_in.event_src = rd_rec.body.event_src;
               res_in.abs_valid = rd_rec.body.abs_valid;
               res_in.status    = (rd_rec.body.tag == work_seq_ff[7:0]) ? ST_OK
                                                                        : ST_TAG_MISMATCH;
            end
            state_in = S_DONE;
         end
         S_ALIGN: begin
            work_seq_in = aligned;
            flag_in     = align_gt;
            state_in    = S_ALIGN2;
         end
         S_ALIGN2: begin
            res_in = '0;
            if (refuse) begin
               res_in.status = ST_ALIGN_REFUSED;
               res_in.seq    = last_ff;
            end else if (flag_ff) begin
               res_in.status = ST_OK;
               res_in.seq    = work_seq_ff;
               last_in       = work_seq_ff;
            end else begin
               res_in.status = ST_OK;
               res_in.seq    = last_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            oldest_in = last_ff - SEQ_W'(count_ff - CNT_W'(1));
            oslot_in  = oslot_wrap[SLOT_W-1:0];
            if (can_push) begin
               rsp_in       = res_ff;
               rsp_in.count = count_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (accept) begin
         op_in      = op_type'(req_opcode);
         time_in    = req_time_seconds;
         delta_in   = req_delta_seconds;
         tsrc_in    = req_time_source;
         esrc_in    = req_event_source;
         abs_in     = req_absolute_valid;
         req_seq_in = req_sequence_req;
         case (op_type'(req_opcode))
            OP_APPEND:      state_in = S_APPEND;
            OP_READ_SEQ:    state_in = S_RANGE;
            OP_READ_NEWEST: state_in = S_RANGE;
            OP_ALIGN:       state_in = S_ALIGN;
            default:        state_in = S_IDLE;
         endcase
      end

      if (csr_we) begin
         case (csr_index)
            REG_MAX_TIME_SRC:  max_ts_in = csr_wdata;
            REG_MAX_EVENT_SRC: max_es_in = csr_wdata;
            default:           max_ts_in = max_ts_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         oldest_ff    <= SEQ_W'(1);
         oslot_ff     <= '0;
         max_ts_ff    <= 3'd7;
         max_es_ff    <= 3'd7;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         oldest_ff    <= oldest_in;
         oslot_ff     <= oslot_in;
         max_ts_ff    <= max_ts_in;
         max_es_ff    <= max_es_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      time_ff     <= time_in;
      delta_ff    <= delta_in;
      tsrc_ff     <= tsrc_in;
      esrc_ff     <= esrc_in;
      abs_ff      <= abs_in;
      req_seq_ff  <= req_seq_in;
      work_seq_ff <= work_seq_in;
      flag_ff     <= flag_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_ff.status;
   assign rsp_result_sequence    = rsp_ff.seq;
   assign rsp_out_time_seconds   = rsp_ff.time_s;
   assign rsp_out_delta_seconds  = rsp_ff.delta;
   assign rsp_out_time_source    = rsp_ff.time_src;
   assign rsp_out_event_source   = rsp_ff.event_src;
   assign rsp_out_absolute_valid = rsp_ff.abs_valid;
   assign rsp_entry_count        = rsp_ff.count;

endmodule

@@ tb/tb_sequenced_event_ring_log.sv @@
// Self-checking testbench for sequenced_event_ring_log: directed table then random
// requests, checked field by field against the table or an in-bench ring log model.
// Depends on serl_pkg and the sequenced_event_ring_log RTL only.
`timescale 1ns / 100ps

module tb_sequenced_event_ring_log;
   import serl_pkg::*;

   localparam int CLK_PERIOD       = 10;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int RANDOM_PER_PHASE = 370;
   localparam int SETTLE_CYCLES    = 6;
   localparam int HOLD_OFF_CYCLES  = 400;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   typedef struct packed {
      op_type      op;
      logic [31:0] time_s;
      logic [16:0] delta;
      logic [2:0]  time_src;
      logic [2:0]  event_src;
      logic        abs_valid;
      logic [63:0] seq;
   } log_request_type;

   typedef struct packed {
      log_request_type req;
      logic            typed;
      result_type      want;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_opcode;
   logic [31:0]           req_time_seconds;
   logic [16:0]           req_delta_seconds;
   logic [2:0]            req_time_source;
   logic [2:0]            req_event_source;
   logic                  req_absolute_valid;
   logic [63:0]           req_sequence_req;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [2:0]            rsp_status;
   logic [63:0]           rsp_result_sequence;
   logic [31:0]           rsp_out_time_seconds;
   logic [16:0]           rsp_out_delta_seconds;
   logic [2:0]            rsp_out_time_source;
   logic [2:0]            rsp_out_event_source;
   logic                  rsp_out_absolute_valid;
   logic [12:0]           rsp_entry_count;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // model of the ring log
   record_type  log_ram [CAPACITY];
   int          log_slot  = 0;
   int          log_count = 0;
   logic [63:0] log_last  = 64'd0;
   logic [2:0]  lim_tsrc  = 3'd7;
   logic [2:0]  lim_esrc  = 3'd7;

   result_type       replies_due [$];
   directed_row_type directed_rows [$];
   result_type       due_reply;
   int               mismatches = 0;
   int               sender_idle_pct;
   int               receiver_idle_pct;
   int               hold_cycles = 0;
   int               cycle_count;

   sequenced_event_ring_log DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_opcode             (req_opcode),
      .req_time_seconds       (req_time_seconds),
      .req_delta_seconds      (req_delta_seconds),
      .req_time_source        (req_time_source),
      .req_event_source       (req_event_source),
      .req_absolute_valid     (req_absolute_valid),
      .req_sequence_req       (req_sequence_req),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_result_sequence    (rsp_result_sequence),
      .rsp_out_time_seconds   (rsp_out_time_seconds),
      .rsp_out_delta_seconds  (rsp_out_delta_seconds),
      .rsp_out_time_source    (rsp_out_time_source),
      .rsp_out_event_source   (rsp_out_event_source),
      .rsp_out_absolute_valid (rsp_out_absolute_valid),
      .rsp_entry_count        (rsp_entry_count),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [7:0] crc8_msb(input logic [63:0] msg);
      logic [7:0] c;
      int         i;
      int         k;
      c = 8'h00;
      for (i = 0; i < 8; i++) begin
         c = c ^ msg[8*i +: 8];
         for (k = 0; k < 8; k++) begin
            if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
            else c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic result_type read_record(input logic [63:0] seq);
      result_type  res;
      record_type  rec;
      logic [63:0] oldest;
      logic [63:0] off;
      int          idx;
      res = '0;
      res.status = ST_NOT_PRESENT;
      oldest = log_last - 64'(log_count) + 64'd1;
      off = seq - oldest;
      if (log_count != 0 && off < 64'(log_count)) begin
         idx = (log_slot + CAPACITY - log_count + int'(off)) % CAPACITY;
         rec = log_ram[idx];
         if (crc8_msb(rec.body) != rec.crc || rec.body.time_src > lim_tsrc
             || rec.body.event_src > lim_esrc) begin
            res.status = ST_INVALID;
         end else begin
            res.time_s    = rec.body.time_s;
            res.delta     = rec.body.delta;
            res.time_src  = rec.body.time_src;
            res.event_src = rec.body.event_src;
            res.abs_valid = rec.body.abs_valid;
            if (rec.body.tag == seq[7:0]) res.status = ST_OK;
            else res.status = ST_TAG_MISMATCH;
         end
      end
      return res;
   endfunction

   function automatic result_type apply_request(input log_request_type r);
      result_type  res;
      record_type  rec;
      logic [63:0] aligned;
      logic [7:0]  fwd;
      res = '0;
      res.status = ST_OK;
      case (r.op)
         OP_APPEND: begin
            log_last = log_last + 64'd1;
            rec.body.time_s    = r.time_s;
            rec.body.delta     = r.delta;
            rec.body.time_src  = r.time_src;
            rec.body.event_src = r.event_src;
            rec.body.abs_valid = r.abs_valid;
            rec.body.tag       = log_last[7:0];
            rec.crc            = crc8_msb(rec.body);
            log_ram[log_slot] = rec;
            log_slot = (log_slot + 1) % CAPACITY;
            if (log_count < CAPACITY) log_count++;
            res.seq = log_last;
         end
         OP_READ_SEQ: begin
            res = read_record(r.seq);
            res.seq = r.seq;
         end
         OP_READ_NEWEST: begin
            res = read_record(log_last);
            res.seq = log_last;
         end
         OP_ALIGN: begin
            if (r.seq > log_last) begin
               aligned = r.seq;
               if (log_count > 0) begin
                  fwd = log_last[7:0] - r.seq[7:0];
                  aligned = r.seq + 64'(fwd);
                  if (aligned < log_last) res.status = ST_ALIGN_REFUSED;
               end
               if (res.status == ST_OK) log_last = aligned;
            end
            res.seq = log_last;
         end
         default: begin
            res.seq = log_last;
         end
      endcase
      res.count = CNT_W'(log_count);
      return res;
   endfunction

   function automatic log_request_type draw_request();
      log_request_type r;
      logic [63:0]     oldest;
      int unsigned     pick;
      int unsigned     sub;
      r.time_s    = $urandom;
      r.delta     = 17'($urandom);
      r.time_src  = 3'($urandom);
      r.event_src = 3'($urandom);
      r.abs_valid = 1'($urandom);
      r.seq       = {$urandom, $urandom};
      oldest = log_last - 64'(log_count) + 64'd1;
      pick = $urandom_range(99);
      sub  = $urandom_range(19);
      if (pick < 40) begin
         r.op = OP_APPEND;
      end else if (pick < 75) begin
         r.op = OP_READ_SEQ;
         if (sub < 16 && log_count != 0) r.seq = oldest + 64'($urandom_range(log_count - 1));
         else if (sub < 18) r.seq = oldest - 64'd1;
         else if (sub < 19) r.seq = log_last + 64'd1;
      end else if (pick < 85) begin
         r.op = OP_READ_NEWEST;
      end else begin
         r.op = OP_ALIGN;
         if (sub < 6) r.seq = log_last - 64'($urandom_range(1000));
         else if (sub < 16) r.seq = log_last + 64'($urandom_range(700, 1));
         else if (sub < 18) r.seq = ~64'd0 - 64'($urandom_range(300));
      end
      return r;
   endfunction

   function automatic void add_row(input op_type op, input logic [31:0] t,
                                   input logic [16:0] d, input logic [2:0] ts,
                                   input logic [2:0] es, input logic av,
                                   input logic [63:0] seq, input logic typed,
                                   input status_type st, input logic [63:0] rseq,
                                   input int cnt);
      directed_row_type row;
      row.req.op        = op;
      row.req.time_s    = t;
      row.req.delta     = d;
      row.req.time_src  = ts;
      row.req.event_src = es;
      row.req.abs_valid = av;
      row.req.seq       = seq;
      row.typed         = typed;
      row.want          = '0;
      row.want.status   = st;
      row.want.seq      = rseq;
      row.want.count    = CNT_W'(cnt);
      directed_rows.push_back(row);
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
   endtask

   task automatic put_request(input log_request_type r, input logic typed,
                              input result_type want);
      result_type pred;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_opcode         = r.op;
      req_time_seconds   = r.time_s;
      req_delta_seconds  = r.delta;
      req_time_source    = r.time_src;
      req_event_source   = r.event_src;
      req_absolute_valid = r.abs_valid;
      req_sequence_req   = r.seq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = apply_request(r);
      if (typed) replies_due.push_back(want);
      else replies_due.push_back(pred);
      @(negedge clock);
   endtask

   task automatic settle_log();
      req_valid = 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx == REG_MAX_TIME_SRC) lim_tsrc = val;
      else if (idx == REG_MAX_EVENT_SRC) lim_esrc = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic hold_receiver();
      req_valid = 1'b0;
      @(posedge clock);
      hold_cycles = HOLD_OFF_CYCLES;
      @(negedge clock);
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready = ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            note_mismatch("response with no request outstanding", rsp_result_sequence, 64'd0);
         end else begin
            due_reply = replies_due.pop_front();
            if (rsp_status !== due_reply.status)
               note_mismatch("status", 64'(rsp_status), 64'(due_reply.status));
            if (rsp_result_sequence !== due_reply.seq)
               note_mismatch("result_sequence", rsp_result_sequence, due_reply.seq);
            if (rsp_out_time_seconds !== due_reply.time_s)
               note_mismatch("out_time_seconds", 64'(rsp_out_time_seconds),
                             64'(due_reply.time_s));
            if (rsp_out_delta_seconds !== due_reply.delta)
               note_mismatch("out_delta_seconds", 64'(rsp_out_delta_seconds),
                             64'(due_reply.delta));
            if (rsp_out_time_source !== due_reply.time_src)
               note_mismatch("out_time_source", 64'(rsp_out_time_source),
                             64'(due_reply.time_src));
            if (rsp_out_event_source !== due_reply.event_src)
               note_mismatch("out_event_source", 64'(rsp_out_event_source),
                             64'(due_reply.event_src));
            if (rsp_out_absolute_valid !== due_reply.abs_valid)
               note_mismatch("out_absolute_valid", 64'(rsp_out_absolute_valid),
                             64'(due_reply.abs_valid));
            if (rsp_entry_count !== due_reply.count)
               note_mismatch("entry_count", 64'(rsp_entry_count), 64'(due_reply.count));
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      log_request_type r;
      int              phase;
      int              n;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_opcode         = OP_APPEND;
      req_time_seconds   = '0;
      req_delta_seconds  = '0;
      req_time_source    = '0;
      req_event_source   = '0;
      req_absolute_valid = 1'b0;
      req_sequence_req   = '0;
      csr_we             = 1'b0;
      csr_index          = REG_MAX_TIME_SRC;
      csr_wdata          = '0;
      sender_idle_pct    = 10;
      receiver_idle_pct  = 65;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(OP_READ_SEQ, 0, 0, 0, 0, 0, 64'd0, 1, ST_NOT_PRESENT, 64'd0, 0);
      add_row(OP_READ_NEWEST, 0, 0, 0, 0, 0, 64'd0, 1, ST_NOT_PRESENT, 64'd0, 0);
      add_row(OP_ALIGN, 0, 0, 0, 0, 0, 64'd0, 1, ST_OK, 64'd0, 0);
      add_row(OP_ALIGN, 0, 0, 0, 0, 0, 64'h1FF, 1, ST_OK, 64'h1FF, 0);
      add_row(OP_APPEND, 0, 0, 0, 0, 0, 64'd0, 1, ST_OK, 64'h200, 1);
      add_row(OP_APPEND, 32'hFFFF_FFFF, 17'h1FFFF, 3'd7, 3'd7, 1'b1, ~64'd0,
              1, ST_OK, 64'h201, 2);
      add_row(OP_READ_SEQ, 0, 0, 0, 0, 0, 64'h200, 0, ST_OK, 0, 0);
      add_row(OP_READ_SEQ, 32'hFFFF_FFFF, 17'h1FFFF, 3'd7, 3'd7, 1'b1, 64'h201,
              0, ST_OK, 0, 0);
      add_row(OP_READ_NEWEST, 0, 0, 0, 0, 0, 64'd0, 0, ST_OK, 0, 0);
      add_row(OP_READ_SEQ, 0, 0, 0, 0, 0, 64'h1FF, 1, ST_NOT_PRESENT, 64'h1FF, 2);
      add_row(OP_READ_SEQ, 0, 0, 0, 0, 0, 64'h202, 1, ST_NOT_PRESENT, 64'h202, 2);
      add_row(OP_READ_SEQ, 0, 0, 0, 0, 0, ~64'd0, 1, ST_NOT_PRESENT, ~64'd0, 2);
      add_row(OP_ALIGN, 0, 0, 0, 0, 0, ~64'd0, 1, ST_ALIGN_REFUSED, 64'h201, 2);
      add_row(OP_ALIGN, 0, 0, 0, 0, 0, 64'h150, 1, ST_OK, 64'h201, 2);
      add_row(OP_ALIGN, 0, 0, 0, 0, 0, 64'h201, 1, ST_OK, 64'h201, 2);
      add_row(OP_ALIGN, 0, 0, 0, 0, 0, 64'h305, 0, ST_OK, 0, 0);
      add_row(OP_READ_SEQ, 0, 0, 0, 0, 0, 64'h401, 0, ST_OK, 0, 0);
      add_row(OP_READ_SEQ, 0, 0, 0, 0, 0, 64'h400, 0, ST_OK, 0, 0);
      add_row(OP_APPEND, 32'h8000_0001, 17'h10000, 3'd4, 3'd3, 1'b0,
              64'h5555_5555_5555_5555, 0, ST_OK, 0, 0);
      add_row(OP_READ_NEWEST, 0, 0, 0, 0, 0, 64'd0, 0, ST_OK, 0, 0);
      add_row(OP_ALIGN, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FF00, 0, ST_OK, 0, 0);
      add_row(OP_APPEND, 32'h1234_5678, 17'h0AAAA, 3'd1, 3'd6, 1'b1,
              64'hAAAA_AAAA_AAAA_AAAA, 0, ST_OK, 0, 0);
      add_row(OP_READ_SEQ, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FF03, 0, ST_OK, 0, 0);
      add_row(OP_READ_SEQ, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FEFF, 0, ST_OK, 0, 0);

      foreach (directed_rows[i])
         put_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      for (phase = 0; phase < 3; phase++) begin
         settle_log();
         case (phase)
            0: begin
               write_register(REG_MAX_TIME_SRC, 3'd0);
               write_register(REG_MAX_EVENT_SRC, 3'd0);
               write_register(REG_SPARE_2, 3'd5);
               write_register(REG_SPARE_3, 3'd2);
               sender_idle_pct   = 10;
               receiver_idle_pct = 65;
            end
            1: begin
               write_register(REG_MAX_TIME_SRC, 3'd7);
               write_register(REG_MAX_EVENT_SRC, 3'd3);
               sender_idle_pct   = 65;
               receiver_idle_pct = 10;
            end
            default: begin
               write_register(REG_MAX_TIME_SRC, 3'd4);
               write_register(REG_MAX_EVENT_SRC, 3'd7);
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 0 && n == 120) hold_receiver();
            if (phase == 1 && n == 150) settle_log();
            r = draw_request();
            put_request(r, 1'b0, '0);
         end
      end

      settle_log();
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
